// ----- rtl/tfpz_pkg.sv -----
// shared types and constants for the two finger pan/zoom gesture block
// no dependencies
package tfpz_pkg;
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_PAN  = 2'd1;
    localparam logic [1:0] MODE_ZOOM = 2'd2;
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_FRAME  = 1'b1;
    localparam logic [1:0] REG_X_LOW  = 2'd0;
    localparam logic [1:0] REG_X_HIGH = 2'd1;
    localparam logic [1:0] REG_Y_LOW  = 2'd2;
    localparam logic [1:0] REG_Y_HIGH = 2'd3;
    localparam int DIV_W = 64;
endpackage

// ----- rtl/tfpz_divider.sv -----
// bit serial restoring divider, one quotient bit per cycle
// depends on tfpz_pkg
module tfpz_divider
    import tfpz_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [DIV_W-1:0] quo
);
    logic [DIV_W-1:0] rem_reg, q_reg, d_reg;
    logic [6:0]       cnt_reg;
    logic             busy_reg;
    logic [DIV_W:0]   trial;
    assign trial = {rem_reg, q_reg[DIV_W-1]} - {1'b0, d_reg};
    assign quo = q_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(DIV_W);
                rem_reg  <= '0;
                q_reg    <= num;
                d_reg    <= den;
            end else if (busy_reg) begin
                if (!trial[DIV_W]) begin
                    rem_reg <= trial[DIV_W-1:0];
                    q_reg   <= {q_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[DIV_W-2:0], q_reg[DIV_W-1]};
                    q_reg   <= {q_reg[DIV_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- rtl/tfpz_isqrt.sv -----
// bit serial integer square root, two radicand bits per cycle
// depends on tfpz_pkg
module tfpz_isqrt
    import tfpz_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] val,
    output logic             done,
    output logic [31:0]      root
);
    logic [DIV_W-1:0] v_reg;
    logic [33:0]      rem_reg;
    logic [31:0]      r_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic [33:0]      shifted, trial;
    assign shifted = {rem_reg[31:0], v_reg[DIV_W-1:DIV_W-2]};
    assign trial   = shifted - {r_reg, 2'b01};
    assign root    = r_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                v_reg    <= val;
                rem_reg  <= '0;
                r_reg    <= '0;
            end else if (busy_reg) begin
                v_reg <= {v_reg[DIV_W-3:0], 2'b00};
                if (!trial[33]) begin
                    rem_reg <= trial;
                    r_reg   <= {r_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    r_reg   <= {r_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- rtl/two_finger_pan_zoom_gesture.sv -----
// top level of the two finger pan/zoom gesture recognizer
// depends on tfpz_pkg, tfpz_divider, tfpz_isqrt
//
// Finger report beats normalize position and motion by the sensor rectangle
// through one shared bit serial divider (four divisions per report, the block
// staying busy until the last is done). An end-of-frame beat walks the slots
// one per cycle, then for two live fingers outside pan multiplies out the drift
// lengths and spread one product per cycle (only the spread in zoom or with no
// live finger), runs the square root and, in zoom, the ratio division before
// its result beat is offered. One beat is handled at a time; a result sits in
// the output register while the next input beat may be taken.
module two_finger_pan_zoom_gesture
    import tfpz_pkg::*;
#(
    parameter int FINGER_SLOTS = 5,
    parameter int FRAC_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // slot, raw_x, raw_y, raw_dx, raw_dy
    input  logic [1:0]  s_tuser,  // op, touching
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // pan_x, pan_y, zoom_step, live_fingers, zero pad
    output logic [1:0]  m_tuser,  // gesture
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int SW = $clog2(FINGER_SLOTS);
    localparam int CW = $clog2(FINGER_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DIV, S_DIVW, S_SCAN, S_DECIDE, S_MUL, S_SQ, S_SQW,
        S_ZDIV, S_ZDIVW, S_AGE, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] xl_reg, xh_reg, yl_reg, yh_reg;
    logic signed [18:0] pos_x_reg [FINGER_SLOTS];
    logic signed [18:0] pos_y_reg [FINGER_SLOTS];
    logic signed [18:0] move_x_reg [FINGER_SLOTS];
    logic signed [18:0] move_y_reg [FINGER_SLOTS];
    logic signed [18:0] org_x_reg [FINGER_SLOTS];
    logic signed [18:0] org_y_reg [FINGER_SLOTS];
    logic signed [19:0] drift_x_reg [FINGER_SLOTS];
    logic signed [19:0] drift_y_reg [FINGER_SLOTS];
    logic [1:0] age_reg [FINGER_SLOTS];
    logic       pres_reg [FINGER_SLOTS];
    logic [1:0] mode_reg;
    logic signed [19:0] panx_reg, pany_reg;
    logic signed [23:0] zstep_reg, ratio_reg;
    logic [19:0] start_reg;

    logic [SW-1:0] slot_reg, idx_reg;
    logic [CW-1:0] live_reg;
    logic [1:0]  dsel_reg;  // which division of a report
    logic [15:0] rx_reg, ry_reg, rdx_reg, rdy_reg;
    logic        setm_reg;  // frame does a gesture reset
    logic [1:0]  newm_reg;
    logic [2:0]  mstep_reg;
    logic signed [63:0] acc_reg, l0_reg;

    // output register
    logic        m_tvalid_q;
    logic [1:0]  o_g_reg;
    logic [19:0] o_px_reg, o_py_reg;
    logic [23:0] o_z_reg;
    logic [4:0]  o_l_reg;

    // divider and root
    logic div_start, div_done, sq_start, sq_done;
    logic [DIV_W-1:0] div_num, div_den, div_q;
    logic [31:0] sq_root;
    logic [DIV_W-1:0] sq_val;
    logic [DIV_W-1:0] num_mag_reg, den_reg;
    logic neg_reg;

    tfpz_divider u_div (
        .aclk, .aresetn, .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_q)
    );
    tfpz_isqrt u_sq (
        .aclk, .aresetn, .start(sq_start), .val(sq_val),
        .done(sq_done), .root(sq_root)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_q;
    assign cfg_ready = 1'b1;
    assign m_tuser   = o_g_reg;
    assign m_tdata   = {3'd0, o_l_reg, o_z_reg, o_py_reg, o_px_reg};

    // report division operand select
    logic signed [17:0] rnum;
    logic [15:0] rspan;
    logic [15:0] lo_s, hi_s;
    always_comb begin
        lo_s = dsel_reg[1] ? yl_reg : xl_reg;
        hi_s = dsel_reg[1] ? yh_reg : xh_reg;
        rspan = (hi_s >= lo_s) ? hi_s - lo_s : lo_s - hi_s;
        case (dsel_reg)
            2'd0: rnum = $signed({2'b00, rx_reg}) - $signed({2'b00, xl_reg});
            2'd1: rnum = 18'(signed'(rdx_reg));
            2'd2: rnum = $signed({2'b00, ry_reg}) - $signed({2'b00, yl_reg});
            default: rnum = 18'(signed'(rdy_reg));
        endcase
    end
    logic [17:0] rmag;
    assign rmag = rnum[17] ? 18'(-rnum) : rnum;

    assign div_start = (state_reg == S_DIV) || (state_reg == S_ZDIV);
    assign div_num   = num_mag_reg;
    assign div_den   = den_reg;
    assign sq_start  = (state_reg == S_SQ);
    assign sq_val    = acc_reg;

    // saturated signed quotient of a report division
    logic [DIV_W-1:0] lim, qs;
    logic signed [18:0] qres;
    always_comb begin
        lim = neg_reg ? 64'd262144 : 64'd262143;
        if (den_reg == '0) qs = (num_mag_reg != '0) ? lim : '0;
        else qs = (div_q > lim) ? lim : div_q;
        qres = neg_reg ? 19'(-$signed({1'b0, qs[18:0]})) : 19'(qs[18:0]);
    end

    // spread differences
    logic signed [19:0] sdx, sdy;
    assign sdx = 20'(pos_x_reg[1]) - 20'(pos_x_reg[0]);
    assign sdy = 20'(pos_y_reg[1]) - 20'(pos_y_reg[0]);

    // one product per cycle in the multiply step
    logic signed [19:0] ma, mb;
    always_comb begin
        case (mstep_reg)
            3'd0: begin ma = drift_x_reg[0]; mb = drift_x_reg[0]; end
            3'd1: begin ma = drift_y_reg[0]; mb = drift_y_reg[0]; end
            3'd2: begin ma = drift_x_reg[1]; mb = drift_x_reg[1]; end
            3'd3: begin ma = drift_y_reg[1]; mb = drift_y_reg[1]; end
            3'd4: begin ma = drift_x_reg[0]; mb = drift_x_reg[1]; end
            3'd5: begin ma = drift_y_reg[0]; mb = drift_y_reg[1]; end
            3'd6: begin ma = sdx; mb = sdx; end
            default: begin ma = sdy; mb = sdy; end
        endcase
    end
    logic signed [39:0] mprod;
    logic signed [63:0] mprod_ext;
    assign mprod     = ma * mb;
    assign mprod_ext = {{24{mprod[39]}}, mprod};

    localparam logic signed [63:0] THR =
        64'(((64'd1 << (2 * FRAC_BITS)) + 64'd9999) / 64'd10000);

    logic [19:0] spread_sat;
    assign spread_sat = (sq_root > 32'd1048575) ? 20'hFFFFF : sq_root[19:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            m_tvalid_q <= 1'b0;
            xl_reg <= 16'd0; xh_reg <= 16'hFFFF;
            yl_reg <= 16'd0; yh_reg <= 16'hFFFF;
            for (int i = 0; i < FINGER_SLOTS; i++) begin
                pos_x_reg[i] <= '0; pos_y_reg[i] <= '0;
                move_x_reg[i] <= '0; move_y_reg[i] <= '0;
                org_x_reg[i] <= '0; org_y_reg[i] <= '0;
                drift_x_reg[i] <= '0; drift_y_reg[i] <= '0;
                age_reg[i] <= 2'd3; pres_reg[i] <= 1'b0;
            end
            mode_reg <= MODE_NONE;
            panx_reg <= '0; pany_reg <= '0; zstep_reg <= '0;
            ratio_reg <= 24'(1 << FRAC_BITS);
            start_reg <= '0;
        end else begin
            if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_X_LOW:  xl_reg <= cfg_data;
                    REG_X_HIGH: xh_reg <= cfg_data;
                    REG_Y_LOW:  yl_reg <= cfg_data;
                    default:    yh_reg <= cfg_data;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        rx_reg <= s_tdata[23:8];  ry_reg <= s_tdata[39:24];
                        rdx_reg <= s_tdata[55:40]; rdy_reg <= s_tdata[71:56];
                        slot_reg <= SW'(s_tdata[7:0]);
                        dsel_reg <= 2'd0;
                        idx_reg <= '0; live_reg <= '0;
                        if (s_tuser[0] == OP_FRAME) state_reg <= S_SCAN;
                        else if (s_tuser[1] && s_tdata[7:0] < 8'(FINGER_SLOTS))
                            state_reg <= S_LOAD;
                    end
                end
                // operands of the next report division
                S_LOAD: begin
                    num_mag_reg <= 64'(rmag) << FRAC_BITS;
                    den_reg     <= 64'(rspan);
                    neg_reg     <= rnum[17];
                    state_reg   <= S_DIV;
                end
                S_DIV: state_reg <= S_DIVW;
                S_DIVW: if (div_done) begin
                    case (dsel_reg)
                        2'd0: pos_x_reg[slot_reg] <= qres;
                        2'd1: move_x_reg[slot_reg] <= qres;
                        2'd2: pos_y_reg[slot_reg] <= qres;
                        default: move_y_reg[slot_reg] <= qres;
                    endcase
                    dsel_reg <= dsel_reg + 2'd1;
                    if (dsel_reg == 2'd3) begin
                        age_reg[slot_reg] <= 2'd0;
                        if (!pres_reg[slot_reg]) begin
                            org_x_reg[slot_reg] <= pos_x_reg[slot_reg];
                            org_y_reg[slot_reg] <= pos_y_reg[slot_reg];
                            pres_reg[slot_reg] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end else state_reg <= S_LOAD;
                end
                S_SCAN: begin
                    if (age_reg[idx_reg] == 2'd3) begin
                        move_x_reg[idx_reg] <= '0; move_y_reg[idx_reg] <= '0;
                        pres_reg[idx_reg] <= 1'b0;
                    end else begin
                        live_reg <= live_reg + CW'(1);
                        drift_x_reg[idx_reg] <= 20'(pos_x_reg[idx_reg])
                            - 20'(org_x_reg[idx_reg]);
                        drift_y_reg[idx_reg] <= 20'(pos_y_reg[idx_reg])
                            - 20'(org_y_reg[idx_reg]);
                    end
                    if (idx_reg == SW'(FINGER_SLOTS - 1)) state_reg <= S_DECIDE;
                    else idx_reg <= idx_reg + SW'(1);
                end
                S_DECIDE: begin
                    if (live_reg == '0) begin
                        // no finger: gesture reset to none, needs the spread
                        setm_reg <= 1'b1; newm_reg <= MODE_NONE;
                        mstep_reg <= 3'd6; state_reg <= S_MUL;
                    end else if (live_reg == CW'(2) && mode_reg == MODE_NONE) begin
                        setm_reg <= 1'b0; mstep_reg <= 3'd0; state_reg <= S_MUL;
                    end else if (live_reg == CW'(2) && mode_reg == MODE_PAN) begin
                        panx_reg <= 20'(move_x_reg[0]) + 20'(move_x_reg[1]);
                        pany_reg <= 20'(move_y_reg[0]) + 20'(move_y_reg[1]);
                        state_reg <= S_AGE;
                    end else if (live_reg == CW'(2)) begin
                        setm_reg <= 1'b0; mstep_reg <= 3'd6; state_reg <= S_MUL;
                    end else state_reg <= S_AGE;
                end
                S_MUL: begin
                    // drift lengths, drift dot product, then squared spread
                    mstep_reg <= mstep_reg + 3'd1;
                    case (mstep_reg)
                        3'd0, 3'd2, 3'd6: acc_reg <= mprod_ext;
                        3'd1: l0_reg <= acc_reg + mprod_ext;
                        3'd3: acc_reg <= acc_reg + mprod_ext;
                        3'd4: begin
                            // acc holds the second drift length here
                            acc_reg <= mprod_ext;
                            if (l0_reg < THR || acc_reg < THR) state_reg <= S_AGE;
                        end
                        3'd5: begin
                            newm_reg <= (acc_reg + mprod_ext > 64'sd0)
                                ? MODE_PAN : MODE_ZOOM;
                            setm_reg <= 1'b1;
                        end
                        default: begin
                            acc_reg <= acc_reg + mprod_ext;
                            state_reg <= S_SQ;
                        end
                    endcase
                end
                S_SQ: state_reg <= S_SQW;
                S_SQW: if (sq_done) begin
                    if (setm_reg) begin
                        mode_reg <= newm_reg;
                        zstep_reg <= '0;
                        ratio_reg <= 24'(1 << FRAC_BITS);
                        start_reg <= spread_sat;
                        setm_reg <= 1'b0;
                        if (newm_reg == MODE_PAN) begin
                            panx_reg <= 20'(move_x_reg[0]) + 20'(move_x_reg[1]);
                            pany_reg <= 20'(move_y_reg[0]) + 20'(move_y_reg[1]);
                        end else begin
                            panx_reg <= '0; pany_reg <= '0;
                        end
                        if (newm_reg == MODE_ZOOM) begin
                            num_mag_reg <= 64'(spread_sat) << FRAC_BITS;
                            den_reg <= 64'(spread_sat);
                            state_reg <= S_ZDIV;
                        end else state_reg <= S_AGE;
                    end else begin
                        num_mag_reg <= 64'(spread_sat) << FRAC_BITS;
                        den_reg <= 64'(start_reg);
                        state_reg <= S_ZDIV;
                    end
                end
                S_ZDIV: state_reg <= S_ZDIVW;
                S_ZDIVW: if (div_done) begin
                    if (den_reg == '0 || div_q > 64'd8388607) begin
                        ratio_reg <= 24'd8388607;
                        zstep_reg <= 24'd8388607 - ratio_reg;
                    end else begin
                        ratio_reg <= div_q[23:0];
                        zstep_reg <= div_q[23:0] - ratio_reg;
                    end
                    state_reg <= S_AGE;
                end
                S_AGE: begin
                    for (int i = 0; i < FINGER_SLOTS; i++)
                        if (age_reg[i] != 2'd3) age_reg[i] <= age_reg[i] + 2'd1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (!m_tvalid_q) begin
                    o_g_reg <= mode_reg; o_px_reg <= panx_reg; o_py_reg <= pany_reg;
                    o_z_reg <= zstep_reg; o_l_reg <= 5'(live_reg);
                    m_tvalid_q <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
